[rtl/bsd_pkg.sv]
// bsd_pkg: shared types, byte codes and crc step for the byte-stuffed deframer
// no dependencies; compiled before the interfaces and modules
package bsd_pkg;

	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE = 8'h7D;
	localparam logic [7:0] ESC_XOR = 8'h20;
	localparam logic [15:0] CRC_POLY = 16'h8408;
	localparam logic [15:0] CRC_INIT = 16'h0000;
	localparam int MIN_CONTENT = 4;
	localparam int MAX_PAYLOAD = 60;
	localparam int PLEN_W = 6;

	localparam logic [1:0] ST_INCOMPLETE = 2'd0;
	localparam logic [1:0] ST_FRAME_READY = 2'd1;
	localparam logic [1:0] ST_CRC_ERR = 2'd2;
	localparam logic [1:0] ST_TOO_LONG = 2'd3;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] seq_num;
		logic [6:0] cmd_code;
		logic resp_bit;
		logic [PLEN_W-1:0] pay_len;
		logic payload_valid;
		logic [7:0] payload_byte;
		logic [PLEN_W-1:0] payload_index;
		logic last;
	} result_item_t;

	// crc-16/kermit, one byte, reflected
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[rtl/bsd_if.sv]
// bsd_raw_if / bsd_result_if: valid/ready channels for raw bytes and result items
// depends on bsd_pkg
interface bsd_raw_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface bsd_result_if import bsd_pkg::*; ();
	logic valid;
	logic ready;
	result_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/byte_stuffed_frame_deframer_crc16.sv]
// byte_stuffed_frame_deframer_crc16: hdlc-like deframer, frame store in a memory
// depends on bsd_pkg and bsd_if
// one registered result item per raw item taken, except a flag that starts a run
// good frame with payload: items pass rd_data_q then out_q, one per cycle unless stalled
// raw: one item per cycle if idle and unstalled; payload run set by the single read port
// reset: mode, count and sequencer clear at once; the frame store is not cleared
module byte_stuffed_frame_deframer_crc16 import bsd_pkg::*; #(
	parameter int MAX_CONTENT = 64
) (
	input logic clk,
	input logic arst_n,
	bsd_raw_if.sink raw,
	bsd_result_if.source result
);

	localparam int CW = $clog2(MAX_CONTENT + 1);
	localparam int AW = $clog2(MAX_CONTENT);

	localparam logic [1:0] MODE_WAIT = 2'd0;
	localparam logic [1:0] MODE_COLLECT = 2'd1;
	localparam logic [1:0] MODE_ESCAPE = 2'd2;

	localparam logic SEQ_IDLE = 1'b0;
	localparam logic SEQ_EMIT = 1'b1;

	logic state_q;
	logic [1:0] mode_q;
	logic [CW-1:0] count_q;
	logic [15:0] crc_q;
	logic [7:0] last1_q, last2_q, hdr0_q, hdr1_q;
	logic [PLEN_W-1:0] plen_q, rd_idx_q, out_idx_q;
	logic rd_valid_q, out_valid_q;
	result_item_t out_q;

	logic [7:0] mem [MAX_CONTENT];
	logic [7:0] rd_data_q;

	logic out_free, accept, wr_en, close_good, go_emit, load_acc, load_pay, rd_en;
	logic [1:0] nxt_mode, acc_status;
	logic [CW-1:0] nxt_count;
	logic [7:0] v, store_val, len8, plen8;
	logic [PLEN_W-1:0] plen;
	logic [6:0] rd_sum;
	logic [AW-1:0] rd_addr;
	logic pay_last;
	result_item_t acc_item, pay_item;

	assign out_free = !out_valid_q || result.ready;
	assign raw.ready = (state_q == SEQ_IDLE) && out_free;
	assign accept = raw.valid && raw.ready;
	assign v = raw.rx_byte;

	assign len8 = 8'(count_q);
	assign plen8 = len8 - 8'(MIN_CONTENT);
	assign plen = (plen8 > 8'(MAX_PAYLOAD)) ? PLEN_W'(MAX_PAYLOAD) : plen8[PLEN_W-1:0];

	always_comb begin
		logic do_store;
		nxt_mode = mode_q;
		nxt_count = count_q;
		do_store = 1'b0;
		store_val = v;
		acc_status = ST_INCOMPLETE;
		close_good = 1'b0;
		case (mode_q)
			MODE_ESCAPE: begin
				nxt_mode = MODE_COLLECT;
				do_store = 1'b1;
				store_val = v ^ ESC_XOR;
			end
			MODE_COLLECT: begin
				if (v == FLAG_BYTE) begin
					if (count_q != '0) begin
						nxt_count = '0;
						if (count_q >= CW'(MIN_CONTENT)) begin
							if (crc_q == {last1_q, last2_q}) begin
								close_good = 1'b1;
								acc_status = ST_FRAME_READY;
							end else begin
								acc_status = ST_CRC_ERR;
							end
						end
					end
				end else if (v == ESC_BYTE) begin
					nxt_mode = MODE_ESCAPE;
				end else begin
					do_store = 1'b1;
				end
			end
			default: begin
				if (v == FLAG_BYTE) begin
					nxt_mode = MODE_COLLECT;
					nxt_count = '0;
				end else begin
					nxt_mode = MODE_WAIT;
				end
			end
		endcase
		wr_en = 1'b0;
		if (do_store) begin
			if (count_q >= CW'(MAX_CONTENT)) begin
				nxt_mode = MODE_WAIT;
				nxt_count = '0;
				acc_status = ST_TOO_LONG;
			end else begin
				wr_en = accept;
				nxt_count = count_q + CW'(1);
			end
		end
	end

	assign go_emit = accept && close_good && (plen != '0);
	assign load_acc = accept && !go_emit;
	assign load_pay = (state_q == SEQ_EMIT) && rd_valid_q && out_free;
	assign rd_en = (state_q == SEQ_EMIT) && (rd_idx_q < plen_q) && (!rd_valid_q || load_pay);
	assign rd_sum = 7'({1'b0, rd_idx_q}) + 7'd2;
	assign rd_addr = rd_sum[AW-1:0];
	assign pay_last = (out_idx_q + PLEN_W'(1)) == plen_q;

	always_comb begin
		acc_item = '0;
		acc_item.status = acc_status;
		acc_item.last = 1'b1;
		if (close_good) begin
			acc_item.seq_num = hdr0_q;
			acc_item.cmd_code = hdr1_q[6:0];
			acc_item.resp_bit = hdr1_q[7];
		end
		pay_item = '0;
		pay_item.status = ST_FRAME_READY;
		pay_item.seq_num = hdr0_q;
		pay_item.cmd_code = hdr1_q[6:0];
		pay_item.resp_bit = hdr1_q[7];
		pay_item.pay_len = plen_q;
		pay_item.payload_valid = 1'b1;
		pay_item.payload_byte = rd_data_q;
		pay_item.payload_index = out_idx_q;
		pay_item.last = pay_last;
	end

	// frame store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[AW-1:0]] <= store_val;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			mode_q <= MODE_WAIT;
			count_q <= '0;
			rd_idx_q <= '0;
			out_idx_q <= '0;
			rd_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				mode_q <= nxt_mode;
				count_q <= nxt_count;
			end
			if (go_emit) begin
				state_q <= SEQ_EMIT;
				rd_idx_q <= '0;
				out_idx_q <= '0;
				rd_valid_q <= 1'b0;
			end else begin
				if (rd_en) begin
					rd_idx_q <= rd_idx_q + PLEN_W'(1);
					rd_valid_q <= 1'b1;
				end else if (load_pay) begin
					rd_valid_q <= 1'b0;
				end
				if (load_pay) begin
					out_idx_q <= out_idx_q + PLEN_W'(1);
					if (pay_last) begin
						state_q <= SEQ_IDLE;
					end
				end
			end
			if (load_acc || load_pay) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// running crc trails the stored bytes by two, header bytes kept aside
	always_ff @(posedge clk) begin
		if (wr_en) begin
			last1_q <= store_val;
			if (count_q == '0) begin
				crc_q <= CRC_INIT;
				hdr0_q <= store_val;
			end else begin
				last2_q <= last1_q;
				if (count_q == CW'(1)) begin
					hdr1_q <= store_val;
				end else begin
					crc_q <= crc_byte(crc_q, last2_q);
				end
			end
		end
		if (go_emit) begin
			plen_q <= plen;
		end
		if (load_acc) begin
			out_q <= acc_item;
		end else if (load_pay) begin
			out_q <= pay_item;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data = out_q;

endmodule

[rtl/bsd_checker.sv]
// bsd_checker: port-level assertions for the deframer, bound into the deframer module
// depends on bsd_pkg and byte_stuffed_frame_deframer_crc16
module bsd_checker import bsd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic raw_valid,
	input logic raw_ready,
	input logic res_valid,
	input logic res_ready,
	input result_item_t res_data
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result item changed while stalled");

	a_single_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.status != ST_FRAME_READY |->
		res_data.last && !res_data.payload_valid && res_data.seq_num == 8'h00
		&& res_data.pay_len == '0)
		else $error("non-frame result carries frame fields");

	a_empty_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.payload_valid |->
		res_data.payload_byte == 8'h00 && res_data.payload_index == '0 && res_data.last)
		else $error("empty payload result malformed");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.payload_valid |->
		res_data.payload_index < res_data.pay_len
		&& res_data.last == (res_data.payload_index + 6'd1 == res_data.pay_len))
		else $error("payload index out of range");

	a_no_take_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		raw_valid && raw_ready |-> !(res_valid && !res_data.last))
		else $error("raw item taken while a payload run is open");

endmodule

bind byte_stuffed_frame_deframer_crc16 bsd_checker u_bsd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.raw_valid(raw.valid),
	.raw_ready(raw.ready),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.res_data(result.data)
);

[verif/bsd_frame_checker.sv]
// bsd_frame_checker: watches the raw byte and result channels of the deframer,
// predicts the result items of every accepted raw byte and compares them in order
// depends on bsd_pkg and the bsd_raw_if / bsd_result_if interfaces
module bsd_frame_checker import bsd_pkg::*; #(
	parameter int MAX_CONTENT = 64
) (
	input logic clk,
	input logic arst_n,
	bsd_raw_if raw,
	bsd_result_if result,
	output int fail_count,
	output int pending,
	output int frames_good,
	output int frames_bad_crc,
	output int frames_too_long,
	output int items_checked
);

	typedef enum logic [1:0] {HUNT, COLLECT, ESCAPED} parse_mode_t;

	parse_mode_t mode;
	logic [6:0] count;
	logic [7:0] store [MAX_CONTENT];
	result_item_t frame_results_q [$];
	result_item_t head;
	result_item_t got;

	function automatic logic [15:0] kermit_crc(input int len);
		logic [15:0] crc;
		logic fb;
		crc = CRC_INIT;
		for (int i = 0; i < len; i++) begin
			for (int k = 0; k < 8; k++) begin
				fb = crc[0] ^ store[i][k];
				crc = crc >> 1;
				if (fb) begin
					crc = crc ^ CRC_POLY;
				end
			end
		end
		return crc;
	endfunction

	function automatic void push_single(input logic [1:0] st);
		result_item_t r;
		r = '0;
		r.status = st;
		r.last = 1'b1;
		frame_results_q.push_back(r);
	endfunction

	function automatic void store_data(input logic [7:0] v);
		if (int'(count) >= MAX_CONTENT) begin
			mode = HUNT;
			count = '0;
			frames_too_long++;
			push_single(ST_TOO_LONG);
		end else begin
			store[count[5:0]] = v;
			count = count + 7'd1;
			push_single(ST_INCOMPLETE);
		end
	endfunction

	function automatic void close_frame();
		int len;
		int plen;
		logic [15:0] rx_crc;
		result_item_t r;
		len = int'(count);
		mode = COLLECT;
		count = '0;
		rx_crc = {store[len - 1], store[len - 2]};
		if (kermit_crc(len - 2) != rx_crc) begin
			frames_bad_crc++;
			push_single(ST_CRC_ERR);
		end else begin
			frames_good++;
			plen = len - MIN_CONTENT;
			if (plen > MAX_PAYLOAD) begin
				plen = MAX_PAYLOAD;
			end
			for (int i = 0; i < ((plen != 0) ? plen : 1); i++) begin
				r = '0;
				r.status = ST_FRAME_READY;
				r.seq_num = store[0];
				r.cmd_code = store[1][6:0];
				r.resp_bit = store[1][7];
				r.pay_len = plen[5:0];
				r.payload_valid = (plen != 0);
				r.payload_byte = (plen != 0) ? store[2 + i] : 8'h00;
				r.payload_index = (plen != 0) ? i[5:0] : 6'd0;
				r.last = (i + 1 >= plen);
				frame_results_q.push_back(r);
			end
		end
	endfunction

	function automatic void deframe_rx_byte(input logic [7:0] b);
		case (mode)
			ESCAPED: begin
				mode = COLLECT;
				store_data(b ^ ESC_XOR);
			end
			COLLECT: begin
				if (b == FLAG_BYTE) begin
					if (count == 7'd0) begin
						push_single(ST_INCOMPLETE);
					end else if (int'(count) < MIN_CONTENT) begin
						count = '0;
						push_single(ST_INCOMPLETE);
					end else begin
						close_frame();
					end
				end else if (b == ESC_BYTE) begin
					mode = ESCAPED;
					push_single(ST_INCOMPLETE);
				end else begin
					store_data(b);
				end
			end
			default: begin
				if (b == FLAG_BYTE) begin
					mode = COLLECT;
					count = '0;
				end else begin
					mode = HUNT;
				end
				push_single(ST_INCOMPLETE);
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] seen);
		if (seen !== want) begin
			$error("%s: expected %0h, got %0h", name, want, seen);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = HUNT;
			count = '0;
			frame_results_q.delete();
			pending = 0;
			fail_count = 0;
			frames_good = 0;
			frames_bad_crc = 0;
			frames_too_long = 0;
			items_checked = 0;
		end else begin
			if (result.valid && result.ready) begin
				got = result.data;
				if (frame_results_q.size() == 0) begin
					$error("result item with no raw byte behind it: %h", got);
					fail_count++;
				end else begin
					head = frame_results_q.pop_front();
					check_field("status", 32'(head.status), 32'(got.status));
					check_field("seq_num", 32'(head.seq_num), 32'(got.seq_num));
					check_field("cmd_code", 32'(head.cmd_code), 32'(got.cmd_code));
					check_field("resp_bit", 32'(head.resp_bit), 32'(got.resp_bit));
					check_field("pay_len", 32'(head.pay_len), 32'(got.pay_len));
					check_field("payload_valid", 32'(head.payload_valid),
						32'(got.payload_valid));
					check_field("payload_byte", 32'(head.payload_byte), 32'(got.payload_byte));
					check_field("payload_index", 32'(head.payload_index),
						32'(got.payload_index));
					check_field("last", 32'(head.last), 32'(got.last));
					items_checked++;
				end
			end
			if (raw.valid && raw.ready) begin
				deframe_rx_byte(raw.rx_byte);
			end
			pending = frame_results_q.size();
		end
	end

endmodule

[verif/tb_byte_stuffed_frame_deframer_crc16.sv]
// tb_byte_stuffed_frame_deframer_crc16: drives stuffed frames, noise and overflows into
// the deframer with bursty input and a stalling receiver; bsd_frame_checker does the checking
// depends on bsd_pkg, bsd_if, the deframer and bsd_frame_checker
module tb_byte_stuffed_frame_deframer_crc16 import bsd_pkg::*; ();

	localparam int STORE_DEPTH = 64;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam int TOTAL_ITEMS = 180;

	logic clk;
	logic arst_n;

	bsd_raw_if raw_ch ();
	bsd_result_if res_ch ();

	int fail_count;
	int pending;
	int frames_good;
	int frames_bad_crc;
	int frames_too_long;
	int items_checked;

	int burst_left;
	int bytes_sent;
	int ignored;
	int hold_asks;
	int choice;
	bit hunting;
	bit esc_all;

	byte_stuffed_frame_deframer_crc16 #(.MAX_CONTENT(STORE_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.raw(raw_ch),
		.result(res_ch)
	);

	bsd_frame_checker #(.MAX_CONTENT(STORE_DEPTH)) chk (
		.clk(clk),
		.arst_n(arst_n),
		.raw(raw_ch),
		.result(res_ch),
		.fail_count(fail_count),
		.pending(pending),
		.frames_good(frames_good),
		.frames_bad_crc(frames_bad_crc),
		.frames_too_long(frames_too_long),
		.items_checked(items_checked)
	);

	always #1 clk = ~clk;

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return FLAG_BYTE;
			1: return ESC_BYTE;
			2: return 8'h5E;
			3: return 8'h5D;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if ($urandom_range(0, 2) != 0) begin
				gap = $urandom_range(1, 6);
			end
		end
		burst_left--;
		@(negedge clk);
		if (gap > 0) begin
			raw_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		raw_ch.valid <= 1'b1;
		raw_ch.rx_byte <= b;
		do @(posedge clk); while (!raw_ch.ready);
		bytes_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		raw_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic send_content(input logic [7:0] b);
		if (b == FLAG_BYTE || b == ESC_BYTE || esc_all || $urandom_range(0, 7) == 0) begin
			send_byte(ESC_BYTE);
			send_byte(b ^ ESC_XOR);
		end else begin
			send_byte(b);
		end
	endtask

	task automatic send_frame(input logic [7:0] seq, input logic [7:0] cmd, input int plen,
			input bit bad_crc, input bit open_flag);
		logic [7:0] body [STORE_DEPTH];
		logic [15:0] crc;
		int n;
		n = plen + MIN_CONTENT;
		body[0] = seq;
		body[1] = cmd;
		for (int i = 2; i < n - 2; i++) begin
			body[i] = pick_byte();
		end
		crc = CRC_INIT;
		for (int i = 0; i < n - 2; i++) begin
			crc = crc_byte(crc, body[i]);
		end
		if (bad_crc) begin
			crc = crc ^ (16'h0001 << $urandom_range(0, 15));
		end
		body[n - 2] = crc[7:0];
		body[n - 1] = crc[15:8];
		if (open_flag || hunting) begin
			send_byte(FLAG_BYTE);
		end
		hunting = 1'b0;
		for (int i = 0; i < n; i++) begin
			send_content(body[i]);
		end
		send_byte(FLAG_BYTE);
	endtask

	task automatic send_noise(input int k);
		logic [7:0] b;
		for (int i = 0; i < k; i++) begin
			b = pick_byte();
			if (hunting) begin
				if (b == FLAG_BYTE) begin
					b = 8'h00;
				end
				ignored++;
			end
			send_byte(b);
		end
	endtask

	task automatic send_overflow();
		send_byte(FLAG_BYTE);
		hunting = 1'b0;
		for (int i = 0; i < STORE_DEPTH; i++) begin
			send_byte(8'($urandom_range(0, 124)));
		end
		if ($urandom_range(0, 1) == 0) begin
			send_byte(ESC_BYTE);
		end
		send_byte(8'($urandom_range(0, 255)));
		hunting = 1'b1;
	endtask

	// receiver: changing stall styles, plus long hold-offs on request
	initial begin
		int phase_left;
		int style;
		int hold_left;
		int seen_asks;
		logic [7:0] mask;
		res_ch.ready = 1'b0;
		phase_left = 0;
		style = 0;
		hold_left = 0;
		seen_asks = 0;
		mask = 8'b1011_0010;
		forever begin
			@(negedge clk);
			if (hold_asks != seen_asks) begin
				seen_asks = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 80);
				style = $urandom_range(0, 3);
			end
			phase_left--;
			mask = {mask[6:0], mask[7]};
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				case (style)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= 1'($urandom_range(0, 1));
					2: res_ch.ready <= ($urandom_range(0, 3) == 0);
					default: res_ch.ready <= mask[0];
				endcase
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d result items still awaited", CYCLE_LIMIT,
			pending);
		$display("tb_byte_stuffed_frame_deframer_crc16: errors");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		raw_ch.valid = 1'b0;
		raw_ch.rx_byte = 8'h00;
		burst_left = 0;
		bytes_sent = 0;
		ignored = 0;
		hold_asks = 0;
		hunting = 1'b1;
		esc_all = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// noise before the first flag
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(ESC_BYTE);
		ignored += 3;
		// opening flag and fill flag
		send_byte(FLAG_BYTE);
		send_byte(FLAG_BYTE);
		hunting = 1'b0;
		// short frame
		send_byte(8'h12);
		send_byte(8'h34);
		send_byte(FLAG_BYTE);
		// empty payload, then bad crc
		send_frame(8'h00, 8'h00, 0, 1'b0, 1'b0);
		send_frame(8'hFF, 8'hFF, 1, 1'b1, 1'b0);
		// every byte escaped, 0x5e goes out as an escaped flag
		esc_all = 1'b1;
		send_frame(8'h5E, 8'h80, 2, 1'b0, 1'b0);
		esc_all = 1'b0;
		drain();

		// frame while the receiver holds off
		hold_asks++;
		send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			$urandom_range(4, 12), 1'b0, 1'b0);
		drain();
		send_overflow();
		send_noise(3);

		while (bytes_sent < TOTAL_ITEMS) begin
			choice = $urandom_range(0, 11);
			if (choice <= 6) begin
				send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					$urandom_range(0, 8), $urandom_range(0, 5) == 0, 1'($urandom_range(0, 1)));
			end else if (choice == 7) begin
				send_noise($urandom_range(1, 6));
			end else if (choice == 8) begin
				send_byte(FLAG_BYTE);
				hunting = 1'b0;
				for (int i = $urandom_range(1, 3); i > 0; i--) begin
					send_byte(8'($urandom_range(0, 124)));
				end
				send_byte(FLAG_BYTE);
			end else if (choice == 9) begin
				for (int i = $urandom_range(1, 3); i > 0; i--) begin
					send_byte(FLAG_BYTE);
				end
				hunting = 1'b0;
			end else if (choice == 10) begin
				drain();
			end else if ($urandom_range(0, 3) == 0) begin
				send_overflow();
			end else begin
				send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					$urandom_range(20, MAX_PAYLOAD), 1'b0, 1'b1);
			end
		end

		drain();
		repeat (10) @(negedge clk);
		$display("sent %0d raw items (%0d ignored), checked %0d result items", bytes_sent,
			ignored, items_checked);
		$display("frames: %0d good, %0d crc errors, %0d too long", frames_good,
			frames_bad_crc, frames_too_long);
		if (fail_count == 0) begin
			$display("tb_byte_stuffed_frame_deframer_crc16: clean");
		end else begin
			$display("tb_byte_stuffed_frame_deframer_crc16: errors");
		end
		$finish;
	end

endmodule
